[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the tilt block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define ATL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked at every edge, reset included.
`define ATL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ATL_ASSERT(lbl, clk, rst_n, prop)
`define ATL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/atl_pkg.sv]
// Types, constants and the arctangent table of the tilt block.
`default_nettype none
package atl_pkg;

    localparam int WINDOW_LEN   = 10;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int WIN_IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int ITER_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam int SUM_W  = 21;
    localparam int DATA_W = 16;

    // Mean by reciprocal multiply, exact for every window sum in range.
    localparam int MEAN_SHIFT = 23;
    localparam int RECIP_W    = 24;
    localparam logic [RECIP_W-1:0] MEAN_RECIP =
        RECIP_W'((2 ** MEAN_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);

    // CORDIC datapath widths.
    localparam int VEC_W   = 38;
    localparam int ANG_W   = 25;
    localparam int RES_W   = 17;
    localparam int GAIN_W  = 32;
    localparam int PROD_W  = 49;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30     = 32'sd1768195363;
    localparam logic signed [ANG_W-1:0]  HALF_TURN_Q8 = 25'sd4608000;
    localparam logic signed [ANG_W-1:0]  ROUND_Q8     = 25'sd128;
    localparam logic signed [RES_W-1:0]  ANG_HALF     = 17'sd18000;
    localparam logic signed [RES_W-1:0]  ANG_QUARTER  = 17'sd9000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROLL,
        ST_PITCH,
        ST_DONE
    } atl_state_t;

    typedef struct packed {
        logic start;
        logic pitch_mode;
    } atl_cordic_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } atl_cordic_sts_t;

    function automatic logic signed [ANG_W-1:0] atan_q8(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 25'sd1152000;
            5'd1:    v = 25'sd680065;
            5'd2:    v = 25'sd359328;
            5'd3:    v = 25'sd182400;
            5'd4:    v = 25'sd91554;
            5'd5:    v = 25'sd45822;
            5'd6:    v = 25'sd22916;
            5'd7:    v = 25'sd11459;
            5'd8:    v = 25'sd5730;
            5'd9:    v = 25'sd2865;
            5'd10:   v = 25'sd1432;
            5'd11:   v = 25'sd716;
            5'd12:   v = 25'sd358;
            5'd13:   v = 25'sd179;
            5'd14:   v = 25'sd90;
            5'd15:   v = 25'sd45;
            5'd16:   v = 25'sd22;
            5'd17:   v = 25'sd11;
            5'd18:   v = 25'sd6;
            5'd19:   v = 25'sd3;
            5'd20:   v = 25'sd1;
            5'd21:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/accel_tilt_angles_with_average.sv]
// Top level: accelerometer window means plus roll and pitch by CORDIC.
//
// Input channel s_*: one transfer carries one sample of three raw words
// (first = x, second = z, third = y). Output channel m_*: one transfer per
// sample with the three window means and the roll and pitch angles.
// The means cover the last 10 samples, with zeros counted before the window
// has filled, and are truncated toward zero. Roll and pitch use the present
// sample, in hundredths of a degree.
// Roll and pitch come from two passes of 16 micro-rotations through the one
// shared CORDIC unit, roll first and pitch second.
// s_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so a new sample may be taken while it waits.
// If the receiver stalls with a result still held, the next result waits
// in the sequencer until that register frees.
// Reset (aresetn low, synchronous) clears the windows, sums and all control.
`default_nettype none
`include "assert_macros.svh"
module accel_tilt_angles_with_average (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [15:0]   s_raw_first_axis,
    input  wire logic signed [15:0]   s_raw_second_axis,
    input  wire logic signed [15:0]   s_raw_third_axis,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_mean_x,
    output logic signed [15:0]        m_mean_y,
    output logic signed [15:0]        m_mean_z,
    output logic signed [15:0]        m_roll_centideg,
    output logic signed [14:0]        m_pitch_centideg
);
    localparam int VW = atl_pkg::VEC_W;
    localparam int PW = atl_pkg::PROD_W;

    atl_pkg::atl_state_t      state_reg, state_next;
    atl_pkg::atl_cordic_cmd_t ccmd;
    atl_pkg::atl_cordic_sts_t csts;

    logic                 in_xfer, out_load;
    logic signed [VW-1:0] c_x, c_y, c_mag;
    logic signed [15:0]   c_angle;
    logic signed [15:0]   ax_reg;
    logic signed [VW-1:0] py_reg;
    logic signed [15:0]   roll_reg;
    logic signed [14:0]   pitch_reg;
    logic signed [15:0]   mx, my, mz;
    logic                 m_valid_reg;
    logic signed [15:0]   o_mx_reg, o_my_reg, o_mz_reg, o_roll_reg;
    logic signed [14:0]   o_pitch_reg;

    assign in_xfer = s_valid && s_ready;

    // Window update happens on the input transfer itself.
    atl_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (in_xfer),
        .x_in    (s_raw_first_axis),
        .y_in    (s_raw_third_axis),
        .z_in    (s_raw_second_axis),
        .mean_x  (mx),
        .mean_y  (my),
        .mean_z  (mz)
    );

    atl_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ccmd),
        .x_in    (c_x),
        .y_in    (c_y),
        .sts     (csts),
        .mag     (c_mag),
        .angle   (c_angle)
    );

    // Pitch second operand: floor(-x * 2^16 * gain / 2^30), i.e. product >>> 14.
    logic signed [16:0]   neg_ax;
    logic signed [PW-1:0] py_prod;
    assign neg_ax  = -17'(ax_reg);
    assign py_prod = PW'(neg_ax) * PW'(atl_pkg::GAIN_Q30);

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ax_reg <= s_raw_first_axis;
        end
        py_reg <= VW'(py_prod >>> 14);
        if (state_reg == atl_pkg::ST_ROLL && csts.done) begin
            roll_reg <= c_angle;
        end
        if (state_reg == atl_pkg::ST_PITCH && csts.done) begin
            pitch_reg <= c_angle[14:0];
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        ccmd.start      = 1'b0;
        ccmd.pitch_mode = 1'b0;
        c_x             = VW'(s_raw_second_axis) <<< 16;
        c_y             = VW'(s_raw_third_axis) <<< 16;
        out_load        = 1'b0;
        unique case (state_reg)
            atl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ccmd.start = 1'b1;
                    state_next = atl_pkg::ST_ROLL;
                end
            end
            atl_pkg::ST_ROLL: begin
                c_x             = c_mag;
                c_y             = py_reg;
                ccmd.pitch_mode = 1'b1;
                if (csts.done) begin
                    ccmd.start = 1'b1;
                    state_next = atl_pkg::ST_PITCH;
                end
            end
            atl_pkg::ST_PITCH: begin
                if (csts.done) begin
                    state_next = atl_pkg::ST_DONE;
                end
            end
            atl_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = atl_pkg::ST_IDLE;
                end
            end
            default: state_next = atl_pkg::ST_IDLE;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_mx_reg    <= mx;
            o_my_reg    <= my;
            o_mz_reg    <= mz;
            o_roll_reg  <= roll_reg;
            o_pitch_reg <= pitch_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mean_x         = o_mx_reg;
    assign m_mean_y         = o_my_reg;
    assign m_mean_z         = o_mz_reg;
    assign m_roll_centideg  = o_roll_reg;
    assign m_pitch_centideg = o_pitch_reg;

    `ATL_ASSERT(a_busy_after_xfer, aclk, aresetn, in_xfer |=> !s_ready)
    `ATL_ASSERT(a_load_shows, aclk, aresetn, out_load |=> m_valid)
    `ATL_ASSERT(a_cordic_idle_in_idle, aclk, aresetn, s_ready |-> !csts.busy)
    `ATL_ASSERT(a_pitch_range, aclk, aresetn, m_valid |-> (m_pitch_centideg <= 15'sd9000 && m_pitch_centideg >= -15'sd9000))
    `ATL_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid && s_ready)
endmodule
`default_nettype wire

[design/atl_window.sv]
// Per-axis sample windows, running sums and window means.
`default_nettype none
module atl_window (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire logic signed [15:0]  x_in,
    input  wire logic signed [15:0]  y_in,
    input  wire logic signed [15:0]  z_in,
    output logic signed [15:0]       mean_x,
    output logic signed [15:0]       mean_y,
    output logic signed [15:0]       mean_z
);
    localparam int IW = atl_pkg::WIN_IDX_W;
    localparam int SW = atl_pkg::SUM_W;
    localparam int QW = atl_pkg::DATA_W + 1;
    localparam int PW = SW + atl_pkg::RECIP_W;

    logic signed [15:0] win_reg [3][atl_pkg::WINDOW_LEN];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [15:0]   mean_reg [3];
    logic [IW-1:0]        pos_reg;
    logic                 upd_reg;
    logic signed [15:0]   smp [3];

    assign smp[0] = x_in;
    assign smp[1] = y_in;
    assign smp[2] = z_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            upd_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                sum_reg[a] <= '0;
                for (int k = 0; k < atl_pkg::WINDOW_LEN; k++) begin
                    win_reg[a][k] <= '0;
                end
            end
        end else begin
            upd_reg <= push;
            if (push) begin
                for (int a = 0; a < 3; a++) begin
                    sum_reg[a] <= sum_reg[a] + SW'(smp[a]) - SW'(win_reg[a][pos_reg]);
                    win_reg[a][pos_reg] <= smp[a];
                end
                if (pos_reg == IW'(atl_pkg::WINDOW_LEN - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
        end
    end

    // Truncating divide: magnitude times reciprocal, sign put back.
    logic [SW-1:0] mag [3];
    logic [PW-1:0] prod [3];
    logic [QW-1:0] quo [3];
    logic [QW-1:0] sq [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag[a]  = sum_reg[a][SW-1] ? SW'(-sum_reg[a]) : SW'(sum_reg[a]);
            prod[a] = PW'(mag[a]) * PW'(atl_pkg::MEAN_RECIP);
            quo[a]  = prod[a][atl_pkg::MEAN_SHIFT +: QW];
            sq[a]   = sum_reg[a][SW-1] ? QW'(-quo[a]) : quo[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_reg) begin
            for (int a = 0; a < 3; a++) begin
                mean_reg[a] <= sq[a][15:0];
            end
        end
    end

    assign mean_x = mean_reg[0];
    assign mean_y = mean_reg[1];
    assign mean_z = mean_reg[2];
endmodule
`default_nettype wire

[design/atl_cordic.sv]
// Shared vectoring CORDIC unit, one micro-rotation per clock while busy.
`default_nettype none
module atl_cordic (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire atl_pkg::atl_cordic_cmd_t            cmd,
    input  wire logic signed [atl_pkg::VEC_W-1:0]    x_in,
    input  wire logic signed [atl_pkg::VEC_W-1:0]    y_in,
    output atl_pkg::atl_cordic_sts_t                 sts,
    output logic signed [atl_pkg::VEC_W-1:0]         mag,
    output logic signed [15:0]                       angle
);
    localparam int VW = atl_pkg::VEC_W;
    localparam int AW = atl_pkg::ANG_W;
    localparam int RW = atl_pkg::RES_W;
    localparam int IW = atl_pkg::ITER_W;

    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [AW-1:0] z_reg;
    logic [IW-1:0]        iter_reg;
    logic                 busy_reg, done_reg, mode_reg;
    logic                 x0neg_reg, x0zero_reg, y0zero_reg, y0pos_reg;

    logic signed [VW-1:0] dx, dy;
    logic signed [AW-1:0] step_ang;

    assign dx       = cy_reg >>> iter_reg;
    assign dy       = cx_reg >>> iter_reg;
    assign step_ang = atl_pkg::atan_q8(5'(iter_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == IW'(atl_pkg::CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mode_reg   <= cmd.pitch_mode;
            x0neg_reg  <= x_in[VW-1];
            x0zero_reg <= (x_in == '0);
            y0zero_reg <= (y_in == '0);
            y0pos_reg  <= !y_in[VW-1];
            if (x_in[VW-1]) begin
                cx_reg <= -x_in;
                cy_reg <= -y_in;
                z_reg  <= y_in[VW-1] ? -atl_pkg::HALF_TURN_Q8 : atl_pkg::HALF_TURN_Q8;
            end else begin
                cx_reg <= x_in;
                cy_reg <= y_in;
                z_reg  <= '0;
            end
        end else if (busy_reg) begin
            if (!cy_reg[VW-1]) begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + step_ang;
            end else begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - step_ang;
            end
        end
    end

    logic signed [AW-1:0] zr;
    logic signed [RW-1:0] r, lim, rc;

    always_comb begin
        zr  = (z_reg + atl_pkg::ROUND_Q8) >>> 8;
        lim = mode_reg ? atl_pkg::ANG_QUARTER : atl_pkg::ANG_HALF;
        priority if (y0zero_reg) begin
            r = x0neg_reg ? atl_pkg::ANG_HALF : '0;
        end else if (x0zero_reg) begin
            r = y0pos_reg ? atl_pkg::ANG_QUARTER : -atl_pkg::ANG_QUARTER;
        end else begin
            r = zr[RW-1:0];
        end
        priority if (r > lim) begin
            rc = lim;
        end else if (r < -lim) begin
            rc = -lim;
        end else begin
            rc = r;
        end
    end

    assign angle     = rc[15:0];
    assign mag       = cx_reg;
    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
endmodule
`default_nettype wire

[sim/testbench.sv]
// Testbench for the accelerometer window-mean and tilt-angle block.
`timescale 1ns / 100ps
module testbench;

    localparam int N_RANDOM  = 1700;
    localparam int WIN       = 10;
    localparam int STEPS     = 16;
    localparam int DRAIN_CYC = 80;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_raw_first_axis = '0;
    logic signed [15:0] s_raw_second_axis = '0;
    logic signed [15:0] s_raw_third_axis = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_mean_x, m_mean_y, m_mean_z, m_roll_centideg;
    logic signed [14:0] m_pitch_centideg;

    typedef struct packed {
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic signed [15:0] mean_z;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } tilt_result_t;

    // Directed row: raw words plus an optional hand-typed expectation.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] z;
        logic signed [15:0] y;
        bit                 typed;
        tilt_result_t       want;
    } sample_row_t;

    tilt_result_t tilt_queue[$];
    int  n_errors = 0;
    bit  rx_stall_en = 1'b1;
    int  rx_hold = 0;

    // Predictor state: per-axis windows and running sums.
    int  hist_x[WIN], hist_y[WIN], hist_z[WIN];
    int  sum_x, sum_y, sum_z;
    int  slot;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    accel_tilt_angles_with_average u_dut (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_raw_first_axis, .s_raw_second_axis, .s_raw_third_axis,
        .m_valid, .m_ready, .m_mean_x, .m_mean_y, .m_mean_z,
        .m_roll_centideg, .m_pitch_centideg
    );

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint atan_entry(int i);
        longint tbl[24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                            11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
                            22, 11, 6, 3, 1, 1, 0, 0};
        return tbl[i];
    endfunction

    // Vectoring CORDIC; returns the clamped angle and the scaled magnitude.
    function automatic int vector_angle(longint cx, longint cy, int lim,
                                        output longint mag);
        longint x0, y0, ang, dx, dy, r;
        x0 = cx;
        y0 = cy;
        ang = 0;
        if (cx < 0) begin
            ang = (cy >= 0) ? 64'sd4608000 : -64'sd4608000;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy >= 0) begin
                cx += dx; cy -= dy; ang += atan_entry(i);
            end else begin
                cx -= dx; cy += dy; ang -= atan_entry(i);
            end
        end
        mag = cx;
        if (y0 == 0)      r = (x0 >= 0) ? 0 : 18000;
        else if (x0 == 0) r = (y0 > 0) ? 9000 : -9000;
        else              r = floor_shift(ang + 128, 8);
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return int'(r);
    endfunction

    function automatic tilt_result_t predict_tilt(int x, int z, int y);
        tilt_result_t res;
        longint mag, spare, py;
        sum_x += x - hist_x[slot]; hist_x[slot] = x;
        sum_y += y - hist_y[slot]; hist_y[slot] = y;
        sum_z += z - hist_z[slot]; hist_z[slot] = z;
        slot = (slot + 1) % WIN;
        res.mean_x = 16'(sum_x / WIN);   // int division truncates toward zero
        res.mean_y = 16'(sum_y / WIN);
        res.mean_z = 16'(sum_z / WIN);
        res.roll = 16'(vector_angle(longint'(z) * 65536, longint'(y) * 65536,
                                    18000, mag));
        py = floor_shift(-longint'(x) * 65536 * 64'sd1768195363, 30);
        res.pitch = 15'(vector_angle(mag, py, 9000, spare));
        return res;
    endfunction

    // Idle gap: mostly none or short, sometimes long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return 16'($urandom_range(0, 40)) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold a sample on the input until it transfers, then predict it.
    // Valid stays high afterwards; the caller drops it before an idle gap.
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] z,
                               logic signed [15:0] y, bit typed, tilt_result_t want);
        tilt_result_t got;
        s_valid <= 1'b1;
        s_raw_first_axis  <= x;
        s_raw_second_axis <= z;
        s_raw_third_axis  <= y;
        do @(posedge aclk); while (!s_ready);
        got = predict_tilt(x, z, y);
        if (typed && got !== want) begin
            $display("%0t predictor disagrees with table: exp %h got %h",
                     $time, want, got);
            n_errors++;
        end
        tilt_queue.push_back(typed ? want : got);
    endtask

    // Result side: random stalls, compare each transfer with the oldest entry.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tilt_result_t exp_r;
                if (tilt_queue.size() == 0) begin
                    $display("%0t unexpected result transfer", $time);
                    n_errors++;
                end else begin
                    exp_r = tilt_queue.pop_front();
                    if (m_mean_x !== exp_r.mean_x) begin
                        $display("%0t mean_x exp %0d got %0d", $time,
                                 exp_r.mean_x, m_mean_x);
                        n_errors++;
                    end
                    if (m_mean_y !== exp_r.mean_y) begin
                        $display("%0t mean_y exp %0d got %0d", $time,
                                 exp_r.mean_y, m_mean_y);
                        n_errors++;
                    end
                    if (m_mean_z !== exp_r.mean_z) begin
                        $display("%0t mean_z exp %0d got %0d", $time,
                                 exp_r.mean_z, m_mean_z);
                        n_errors++;
                    end
                    if (m_roll_centideg !== exp_r.roll) begin
                        $display("%0t roll exp %0d got %0d", $time,
                                 exp_r.roll, m_roll_centideg);
                        n_errors++;
                    end
                    if (m_pitch_centideg !== exp_r.pitch) begin
                        $display("%0t pitch exp %0d got %0d", $time,
                                 exp_r.pitch, m_pitch_centideg);
                        n_errors++;
                    end
                end
            end
            // Mostly short stalls, now and then a long one.
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_stall_en && $urandom_range(0, 199) == 0) begin
                rx_hold = $urandom_range(20, 90);
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_stall_en || ($urandom_range(0, 99) < 70);
            end
        end
    end

    function automatic tilt_result_t mk(int mx, int my, int mz, int r, int p);
        tilt_result_t t;
        t.mean_x = 16'(mx); t.mean_y = 16'(my); t.mean_z = 16'(mz);
        t.roll = 16'(r); t.pitch = 15'(p);
        return t;
    endfunction

    initial begin
        sample_row_t rows[$];
        sample_row_t row;
        int gap;

        for (int i = 0; i < WIN; i++) begin
            hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
        end
        sum_x = 0; sum_y = 0; sum_z = 0; slot = 0;

        // Directed rows (x, z, y). Typed ones follow from a fresh window.
        rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, mk(0, 0, 0, 0, 0)});
        // z positive only: roll 0 (zero y), pitch 0 (zero -x)
        rows.push_back('{16'sd0, 16'sd100, 16'sd0, 1'b1, mk(0, 0, 10, 0, 0)});
        // z negative, y zero: roll 18000
        rows.push_back('{16'sd0, -16'sd100, 16'sd0, 1'b1, mk(0, 0, 0, 18000, 0)});
        // y only: roll +9000 via zero first operand
        rows.push_back('{16'sd0, 16'sd0, 16'sd50, 1'b1, mk(0, 5, 0, 9000, 0)});
        rows.push_back('{16'sd0, 16'sd0, -16'sd50, 1'b1, mk(0, 0, 0, -9000, 0)});
        // x only: magnitude zero, pitch quarter turn
        rows.push_back('{16'sd1000, 16'sd0, 16'sd0, 1'b1, mk(100, 0, 0, 0, -9000)});
        rows.push_back('{-16'sd1000, 16'sd0, 16'sd0, 1'b1, mk(0, 0, 0, 0, 9000)});
        rows.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh0001, -16'sd1, 16'sh0001, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{-16'sd1, -16'sd1, -16'sd1, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, mk(0, 0, 0, 0, 0)});
        rows.push_back('{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, mk(0, 0, 0, 0, 0)});
        for (int i = 0; i < 6; i++)   // six more rows at the negative extreme
            rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, mk(0, 0, 0, 0, 0)});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            row = rows[i];
            send_sample(row.x, row.z, row.y, row.typed, row.want);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            gap = gap_len();
            if (gap > 0 || n == N_RANDOM / 2) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // Stretches without receiver stalls now and then.
            if (n % 300 == 0) rx_stall_en = ~rx_stall_en;
            // Drain the block fully once mid-run.
            if (n == N_RANDOM / 2) begin
                while (tilt_queue.size() != 0) @(posedge aclk);
            end
            send_sample(rand_word(), rand_word(), rand_word(), 1'b0,
                        mk(0, 0, 0, 0, 0));
        end
        s_valid <= 1'b0;

        while (tilt_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (n_errors == 0 && tilt_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Slowest run of 1722 items, with their gaps and stalls, stays well under this.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/atl_pkg.sv
design/atl_window.sv
design/atl_cordic.sv
design/accel_tilt_angles_with_average.sv
sim/testbench.sv
